// ===== rtl/kpsd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the keypad scan and digit entry core: key codes, key map,
// segment table and the accept record passed between the debounce and entry logic.
// No dependencies.
package kpsd_pkg;

    localparam int SCAN_LINES = 4;
    localparam int ROW_W      = $clog2(SCAN_LINES);
    localparam int COL_W      = 4;
    localparam int KEY_W      = 5;
    localparam int TIME_W     = 32;
    localparam int DEB_W      = 16;
    localparam int DIGITS     = 4;
    localparam int DIGIT_W    = 4;
    localparam int VALUE_W    = 14;
    localparam int SEG_W      = 8;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    localparam key_t KEY_NONE    = 5'd16;
    localparam key_t KEY_STAR    = 5'd14;
    localparam key_t KEY_POUND   = 5'd15;
    localparam key_t DIGIT_LIMIT = 5'd10;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd70;
    localparam row_t             CURSOR_RESET   = 2'd3;

    // Row-major key map, columns 0..3 left to right.
    localparam key_t KEY_MAP [SCAN_LINES][COL_W] = '{
        '{5'd1,     5'd2, 5'd3,      5'd10},
        '{5'd4,     5'd5, 5'd6,      5'd11},
        '{5'd7,     5'd8, 5'd9,      5'd12},
        '{KEY_STAR, 5'd0, KEY_POUND, 5'd13}
    };

    // Record of one debounced acceptance.
    typedef struct packed {
        logic hit;   // a new, non-released stable key this tick
        key_t key;   // accepted key, KEY_NONE when hit is low
    } kpsd_accept_t;

    // Active-low columns; the lowest pressed column wins.
    function automatic key_t decode_row(input row_t row, input logic [COL_W-1:0] cols);
        key_t k;
        k = KEY_NONE;
        priority if (!cols[0]) k = KEY_MAP[row][0];
        else if (!cols[1])     k = KEY_MAP[row][1];
        else if (!cols[2])     k = KEY_MAP[row][2];
        else if (!cols[3])     k = KEY_MAP[row][3];
        else                   k = KEY_NONE;
        return k;
    endfunction

    // bit7 = a ... bit1 = g, bit0 unused.
    function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hE6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/kpsd_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the keypad scan core: the column sample
// channel and the display/result channel. Depends on kpsd_pkg.
interface kpsd_sample_if;
    logic                       valid;
    logic                       ready;
    logic [kpsd_pkg::COL_W-1:0]  column_lines;
    logic [kpsd_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output column_lines, output now_ms, input ready);
    modport sink   (input valid, input column_lines, input now_ms, output ready);
endinterface

interface kpsd_result_if;
    logic                        valid;
    logic                        ready;
    logic [kpsd_pkg::ROW_W-1:0]   scanned_row;
    logic [kpsd_pkg::SEG_W-1:0]   segments;
    logic [kpsd_pkg::VALUE_W-1:0] entered_value;
    logic [kpsd_pkg::ROW_W-1:0]   cursor_digit;
    logic [kpsd_pkg::KEY_W-1:0]   accepted_key;

    modport source (output valid, output scanned_row, output segments,
                    output entered_value, output cursor_digit, output accepted_key,
                    input ready);
    modport sink   (input valid, input scanned_row, input segments,
                    input entered_value, input cursor_digit, input accepted_key,
                    output ready);
endinterface

// ===== rtl/kpsd_debounce.sv =====
`timescale 1ns / 1ps
// Per-row raw/stable key tracking with one shared change timestamp.
// Depends on kpsd_pkg.
module kpsd_debounce (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  kpsd_pkg::row_t              row,
    input  kpsd_pkg::key_t              key,
    input  logic [kpsd_pkg::TIME_W-1:0] now_ms,
    input  logic [kpsd_pkg::DEB_W-1:0]  debounce_ms,
    output kpsd_pkg::kpsd_accept_t      acc
);
    import kpsd_pkg::*;

    key_t              raw_prev_reg [SCAN_LINES];
    key_t              stable_reg   [SCAN_LINES];
    logic [TIME_W-1:0] change_time_reg;

    logic              raw_changed;
    logic [TIME_W-1:0] elapsed;
    logic              settle;

    always_comb
    begin
        raw_changed = (key != raw_prev_reg[row]);
        elapsed     = now_ms - change_time_reg;
        // A fresh raw change restarts the timer and blocks settling in that tick.
        settle      = !raw_changed && (elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce_ms})
                      && (key != stable_reg[row]);
        acc.hit     = settle && (key != KEY_NONE);
        acc.key     = acc.hit ? key : KEY_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCAN_LINES; i++)
            begin
                raw_prev_reg[i] <= KEY_NONE;
                stable_reg[i]   <= KEY_NONE;
            end
            change_time_reg <= '0;
        end
        else if (adv)
        begin
            raw_prev_reg[row] <= key;
            if (raw_changed)
                change_time_reg <= now_ms;
            if (settle)
                stable_reg[row] <= key;
        end
    end

endmodule

// ===== rtl/kpsd_entry.sv =====
`timescale 1ns / 1ps
// Digit entry: edit cursor, four decimal digits, decimal value and segments
// of the scanned digit, all given as post-update values. Depends on kpsd_pkg.
module kpsd_entry (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  kpsd_pkg::row_t               row,
    input  kpsd_pkg::kpsd_accept_t       acc,
    output logic [kpsd_pkg::SEG_W-1:0]   segments,
    output logic [kpsd_pkg::VALUE_W-1:0] entered_value,
    output kpsd_pkg::row_t               cursor_digit
);
    import kpsd_pkg::*;

    row_t   cursor_reg;
    row_t   cursor_next;
    digit_t digits_reg  [DIGITS];
    digit_t digits_next [DIGITS];

    always_comb
    begin
        cursor_next = cursor_reg;
        for (int i = 0; i < DIGITS; i++)
            digits_next[i] = digits_reg[i];
        if (acc.hit)
        begin
            if (acc.key == KEY_POUND)
                cursor_next = cursor_reg - 2'd1;   // wraps 0 -> 3
            else if (acc.key < DIGIT_LIMIT)
                digits_next[cursor_reg] = acc.key[DIGIT_W-1:0];
        end
        segments      = seg_of(digits_next[row]);
        entered_value = VALUE_W'(digits_next[3]) * VALUE_W'(1000)
                      + VALUE_W'(digits_next[2]) * VALUE_W'(100)
                      + VALUE_W'(digits_next[1]) * VALUE_W'(10)
                      + VALUE_W'(digits_next[0]);
        cursor_digit  = cursor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= CURSOR_RESET;
            for (int i = 0; i < DIGITS; i++)
                digits_reg[i] <= '0;
        end
        else if (adv)
        begin
            cursor_reg <= cursor_next;
            for (int i = 0; i < DIGITS; i++)
                digits_reg[i] <= digits_next[i];
        end
    end

endmodule

// ===== rtl/keypad_scan_digit_entry_core.sv =====
`timescale 1ns / 1ps
// Top level of the 4x4 keypad scanner with debounce and four-digit entry.
// Depends on kpsd_pkg, kpsd_ifs, kpsd_debounce and kpsd_entry.
//
// Usage:
//   sample channel: one transaction per scan tick, carrying the active-low
//     column sample of the row being driven and the millisecond time stamp.
//   result channel: one transaction per sample; names the row scanned in that
//     tick (drive it low, enable its digit), its segment pattern, the entered
//     value, the edit cursor and any newly accepted key.
//   debounce_ms is to be written through cfg_we/cfg_wdata while the block is idle; the block does not enforce it.
// Timing: a sample is held in an input register, then logic updates the key
//   and digit state and loads the result register when the input register
//   advances; the result then stays valid in the result register until taken.
//   One sample is taken every cycle while results drain.
// Stall: while a result waits, the input register holds its sample and the
//   sample channel takes a transaction only when that register is empty or
//   advances in the same cycle.
// Reset: row 0 first, all keys released, digits 0, cursor on the thousands
//   place, debounce 70 ms, change timestamp 0, both channels empty.
module keypad_scan_digit_entry_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [kpsd_pkg::DEB_W-1:0] cfg_wdata,
    kpsd_sample_if.sink                sample,
    kpsd_result_if.source              result
);
    import kpsd_pkg::*;

    // Configuration
    logic [DEB_W-1:0] debounce_reg;

    // Input register
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_cols_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_adv;

    // Scan position
    row_t scan_row_reg;

    // Stage logic
    key_t             key;
    kpsd_accept_t     acc;
    logic [SEG_W-1:0] seg_next;
    logic [VALUE_W-1:0] value_next;
    row_t             cursor_next;

    // Result register
    logic               res_valid_reg;
    row_t               res_row_reg;
    logic [SEG_W-1:0]   res_seg_reg;
    logic [VALUE_W-1:0] res_value_reg;
    row_t               res_cursor_reg;
    key_t               res_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (cfg_we)
            debounce_reg <= cfg_wdata;
    end

    // Advance the held sample whenever the result register is free or drains.
    assign s1_adv       = s1_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sample.ready)
            s1_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            s1_cols_reg <= sample.column_lines;
            s1_now_reg  <= sample.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_row_reg <= '0;
        else if (s1_adv)
            scan_row_reg <= scan_row_reg + 1'b1;
    end

    assign key = decode_row(scan_row_reg, s1_cols_reg);

    kpsd_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .row         (scan_row_reg),
        .key         (key),
        .now_ms      (s1_now_reg),
        .debounce_ms (debounce_reg),
        .acc         (acc)
    );

    kpsd_entry u_entry (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (s1_adv),
        .row           (scan_row_reg),
        .acc           (acc),
        .segments      (seg_next),
        .entered_value (value_next),
        .cursor_digit  (cursor_next)
    );

    // Load the result on advance; drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_adv)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_row_reg    <= scan_row_reg;
            res_seg_reg    <= seg_next;
            res_value_reg  <= value_next;
            res_cursor_reg <= cursor_next;
            res_key_reg    <= acc.key;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.scanned_row   = res_row_reg;
    assign result.segments      = res_seg_reg;
    assign result.entered_value = res_value_reg;
    assign result.cursor_digit  = res_cursor_reg;
    assign result.accepted_key  = res_key_reg;

`ifndef SYNTHESIS
    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> scan_row_reg == $past(scan_row_reg) + 2'd1)
        else $error("scan row did not advance by one");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> sample.ready)
        else $error("sample channel stalled with empty result register");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_value_reg <= 14'd9999)
        else $error("entered value out of decimal range");
`endif

endmodule
